>>> design/cfe_pkg.sv
package cfe_pkg;

   // fixed field widths of the transactions
   localparam int DATA_W  = 8;
   localparam int ADDR_W  = 8;
   localparam int LEN_W   = 9;
   localparam int RUN_W   = 8;

   // writes one payload byte can cause: data, code patch, final code, terminator
   localparam int SLOTS   = 4;
   localparam int SLOT_W  = $clog2(SLOTS);

   // slot roles inside a queued entry
   localparam int SLOT_FIRST  = 0;
   localparam int SLOT_SPLIT  = 1;
   localparam int SLOT_CLOSE  = 2;
   localparam int SLOT_TERM   = 3;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one frame memory write
   typedef struct packed {
      logic [ADDR_W-1:0] frame_addr;
      logic [DATA_W-1:0] frame_value;
      logic              frame_end;
      logic [LEN_W-1:0]  frame_length;
   } slot_type;

   // all writes of one payload byte, with the sticky overflow after that byte
   typedef struct packed {
      logic [SLOTS-1:0] mask;
      logic             overflow;
      slot_type [SLOTS-1:0] slot;
   } entry_type;

endpackage

>>> design/cfe_front.sv
module cfe_front #(
   parameter int FRAME_DEPTH = 256,
   parameter int MAX_RUN     = 254
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cfe_pkg::DATA_W-1:0] req_data_byte,
   input  logic                       req_last_byte,
   input  logic                       queue_full,
   output logic                       push,
   output cfe_pkg::entry_type         push_entry
);

   localparam int POS_W = $clog2(FRAME_DEPTH + 1);
   localparam int AX_W  = (POS_W > cfe_pkg::ADDR_W) ? POS_W : cfe_pkg::ADDR_W;
   localparam int LX_W  = (POS_W + 1 > cfe_pkg::LEN_W) ? POS_W + 1 : cfe_pkg::LEN_W;

   logic [POS_W-1:0]          code_pos_ff, code_pos_in;
   logic [POS_W-1:0]          write_pos_ff, write_pos_in;
   logic [cfe_pkg::RUN_W-1:0] run_ff, run_in;
   logic                      ovf_ff, ovf_in;

   logic                      accept;
   logic                      nonzero, hit, closed, clamp;
   logic [POS_W-1:0]          wp1, cp1, wp2, cp2, taddr;
   logic [cfe_pkg::RUN_W-1:0] run1, run2;
   logic [POS_W-1:0]          addr0;
   logic [cfe_pkg::DATA_W-1:0] val0;
   logic                      ok0, ok1, ok2;
   logic                      ovf_next;
   logic [LX_W-1:0]           len_x;

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
      return (p < POS_W'(FRAME_DEPTH)) ? p + POS_W'(1) : p;
   endfunction

   function automatic logic [cfe_pkg::ADDR_W-1:0] low_addr(input logic [POS_W-1:0] p);
      logic [AX_W-1:0] x;
      x = AX_W'(p);
      return x[cfe_pkg::ADDR_W-1:0];
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // classify the byte and work out its writes
   always_comb begin
      nonzero = (req_data_byte != '0);
      addr0   = nonzero ? write_pos_ff : code_pos_ff;
      val0    = nonzero ? req_data_byte : run_ff + cfe_pkg::RUN_W'(1);
      ok0     = addr0 < POS_W'(FRAME_DEPTH);

      wp1  = sat_inc(write_pos_ff);
      run1 = nonzero ? run_ff + cfe_pkg::RUN_W'(1) : '0;
      cp1  = nonzero ? code_pos_ff : write_pos_ff;

      hit    = nonzero && (run1 >= cfe_pkg::RUN_W'(MAX_RUN));
      closed = hit && req_last_byte;
      ok1    = cp1 < POS_W'(FRAME_DEPTH);

      if (hit && !req_last_byte) begin
         cp2  = wp1;
         wp2  = sat_inc(wp1);
         run2 = '0;
      end else begin
         cp2  = cp1;
         wp2  = wp1;
         run2 = run1;
      end
      ok2 = cp2 < POS_W'(FRAME_DEPTH);

      clamp = wp2 >= POS_W'(FRAME_DEPTH);
      taddr = clamp ? POS_W'(FRAME_DEPTH - 1) : wp2;
      len_x = LX_W'(taddr) + LX_W'(1);

      ovf_next = ovf_ff | !ok0 | (hit & !ok1)
               | (req_last_byte & !closed & !ok2)
               | (req_last_byte & clamp);
   end

   // pack the entry for the back part
   always_comb begin
      push_entry = '0;
      push_entry.overflow = ovf_next;

      push_entry.mask[cfe_pkg::SLOT_FIRST] = ok0;
      push_entry.slot[cfe_pkg::SLOT_FIRST].frame_addr  = low_addr(addr0);
      push_entry.slot[cfe_pkg::SLOT_FIRST].frame_value = val0;

      push_entry.mask[cfe_pkg::SLOT_SPLIT] = hit && ok1;
      push_entry.slot[cfe_pkg::SLOT_SPLIT].frame_addr  = low_addr(cp1);
      push_entry.slot[cfe_pkg::SLOT_SPLIT].frame_value = run1 + cfe_pkg::RUN_W'(1);

      push_entry.mask[cfe_pkg::SLOT_CLOSE] = req_last_byte && !closed && ok2;
      push_entry.slot[cfe_pkg::SLOT_CLOSE].frame_addr  = low_addr(cp2);
      push_entry.slot[cfe_pkg::SLOT_CLOSE].frame_value = run2 + cfe_pkg::RUN_W'(1);

      push_entry.mask[cfe_pkg::SLOT_TERM] = req_last_byte;
      push_entry.slot[cfe_pkg::SLOT_TERM].frame_addr   = low_addr(taddr);
      push_entry.slot[cfe_pkg::SLOT_TERM].frame_end    = 1'b1;
      push_entry.slot[cfe_pkg::SLOT_TERM].frame_length = len_x[cfe_pkg::LEN_W-1:0];
   end

   // drop entries that carry no write
   assign push = accept && (push_entry.mask != '0);

   // advance frame state; return to start after the terminator
   always_comb begin
      code_pos_in  = code_pos_ff;
      write_pos_in = write_pos_ff;
      run_in       = run_ff;
      ovf_in       = ovf_ff;
      if (accept) begin
         if (req_last_byte) begin
            code_pos_in  = '0;
            write_pos_in = POS_W'(1);
            run_in       = '0;
            ovf_in       = 1'b0;
         end else begin
            code_pos_in  = cp2;
            write_pos_in = wp2;
            run_in       = run2;
            ovf_in       = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_pos_ff  <= '0;
         write_pos_ff <= POS_W'(1);
         run_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         code_pos_ff  <= code_pos_in;
         write_pos_ff <= write_pos_in;
         run_ff       <= run_in;
         ovf_ff       <= ovf_in;
      end
   end

endmodule

>>> design/cfe_queue.sv
module cfe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cfe_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output cfe_pkg::entry_type head_entry
);

   cfe_pkg::entry_type entry_ff [cfe_pkg::QUEUE_DEPTH];

   logic [cfe_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cfe_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cfe_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full       = (count_ff == cfe_pkg::QCNT_W'(cfe_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == cfe_pkg::QPTR_W'(cfe_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + cfe_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == cfe_pkg::QPTR_W'(cfe_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + cfe_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + cfe_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - cfe_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entry payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> design/cfe_back.sv
module cfe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  cfe_pkg::entry_type         head_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cfe_pkg::ADDR_W-1:0] rsp_frame_addr,
   output logic [cfe_pkg::DATA_W-1:0] rsp_frame_value,
   output logic                       rsp_frame_end,
   output logic                       rsp_overflow,
   output logic [cfe_pkg::LEN_W-1:0]  rsp_frame_length
);

   cfe_pkg::entry_type         cur_ff, cur_in;
   logic [cfe_pkg::SLOTS-1:0]  mask_ff, mask_in;
   cfe_pkg::slot_type          out_slot_ff, out_slot_in;
   logic                       out_ovf_ff, out_ovf_in;
   logic                       out_valid_ff, out_valid_in;

   logic                       out_free, pick;
   logic [cfe_pkg::SLOT_W-1:0] sel;
   logic [cfe_pkg::SLOTS-1:0]  mask_after;

   assign out_free = !out_valid_ff || rsp_ready;
   assign pick     = out_free && (mask_ff != '0);

   // find the lowest pending write of the current entry
   always_comb begin
      sel = '0;
      for (int i = cfe_pkg::SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = cfe_pkg::SLOT_W'(i);
         end
      end
   end

   always_comb begin
      mask_after = mask_ff;
      if (pick) begin
         mask_after[sel] = 1'b0;
      end
   end

   // pull the next entry as the current one runs out
   assign pop = head_valid && (mask_after == '0);

   always_comb begin
      cur_in  = cur_ff;
      mask_in = mask_after;
      if (pop) begin
         cur_in  = head_entry;
         mask_in = head_entry.mask;
      end
   end

   // load or hold the output register
   always_comb begin
      out_slot_in  = out_slot_ff;
      out_ovf_in   = out_ovf_ff;
      out_valid_in = out_valid_ff;
      if (pick) begin
         out_slot_in  = cur_ff.slot[sel];
         out_ovf_in   = cur_ff.overflow;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_slot_ff <= out_slot_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_addr   = out_slot_ff.frame_addr;
   assign rsp_frame_value  = out_slot_ff.frame_value;
   assign rsp_frame_end    = out_slot_ff.frame_end;
   assign rsp_overflow     = out_ovf_ff;
   assign rsp_frame_length = out_slot_ff.frame_length;

endmodule

>>> design/cobs_frame_encoder_unit.sv
// Channel | Direction | Signals
// --------+-----------+---------------------------------------------------------------
// req     | in        | req_valid, req_ready, req_data_byte, req_last_byte
// rsp     | out       | rsp_valid, rsp_ready, rsp_frame_addr, rsp_frame_value,
//         |           | rsp_frame_end, rsp_overflow, rsp_frame_length
//
// The front takes one payload byte per cycle while the queue is not full and turns
// it into all its frame writes in that cycle; a two-entry queue hands them to the back.
// The back issues one write per cycle unless an rsp stall holds the output register;
// a byte yields one write for a plain or zero byte, two on a full run, three at frame end.
// Reset is synchronous and clears frame state, queue and output register.
// req_ready drops only while the queue is full; rsp stalls hold the output register.
module cobs_frame_encoder_unit #(
   parameter int FRAME_DEPTH = 256,
   parameter int MAX_RUN     = 254
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cfe_pkg::DATA_W-1:0] req_data_byte,
   input  logic                       req_last_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cfe_pkg::ADDR_W-1:0] rsp_frame_addr,
   output logic [cfe_pkg::DATA_W-1:0] rsp_frame_value,
   output logic                       rsp_frame_end,
   output logic                       rsp_overflow,
   output logic [cfe_pkg::LEN_W-1:0]  rsp_frame_length
);

   logic               push, queue_full, pop, head_valid;
   cfe_pkg::entry_type push_entry, head_entry;

   cfe_front #(
      .FRAME_DEPTH (FRAME_DEPTH),
      .MAX_RUN     (MAX_RUN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   cfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   cfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_addr   (rsp_frame_addr),
      .rsp_frame_value  (rsp_frame_value),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_overflow     (rsp_overflow),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int DATA_W       = cfe_pkg::DATA_W;
   localparam int ADDR_W       = cfe_pkg::ADDR_W;
   localparam int LEN_W        = cfe_pkg::LEN_W;
   localparam int FRAME_DEPTH  = 256;
   localparam int MAX_RUN      = 254;
   localparam int RANDOM_ITEMS = 170;
   localparam int HOLD_OFF     = 200;
   localparam int HOLD_AT      = 20;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_PRINTS   = 60;
   localparam int LIMIT        = 400000;

   // one payload byte waiting to be offered
   typedef struct {
      logic [DATA_W-1:0] data;
      logic              last;
      bit                hold;
   } payload_item_type;

   // one expected frame memory write
   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] value;
      logic              term;
      logic              ovf;
      logic [LEN_W-1:0]  length;
   } frame_write_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_data_byte = '0;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ADDR_W-1:0] rsp_frame_addr;
   logic [DATA_W-1:0] rsp_frame_value;
   logic              rsp_frame_end;
   logic              rsp_overflow;
   logic [LEN_W-1:0]  rsp_frame_length;

   payload_item_type pending_bytes[$];
   frame_write_type  frame_writes[$];
   frame_write_type  step_writes[$];

   // encoder state of the predictor
   int unsigned code_pos  = 0;
   int unsigned write_pos = 1;
   int unsigned run_len   = 0;
   bit          ovf_seen  = 1'b0;

   logic [31:0] cycle_count = '0;
   int          error_count = 0;
   int          writes_seen = 0;
   bit          req_fire = 1'b0;
   bit          rsp_fire = 1'b0;
   bit          offering = 1'b0;
   int          req_gap = 0;
   int          rsp_wait = 0;
   int          random_count;
   int          zero_pct;
   int          frame_len;

   // one quarter of the time neither side idles
   wire no_idle = (cycle_count[9:8] == 2'd1);

   cobs_frame_encoder_unit #(
      .FRAME_DEPTH(FRAME_DEPTH),
      .MAX_RUN    (MAX_RUN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_addr  (rsp_frame_addr),
      .rsp_frame_value (rsp_frame_value),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_overflow    (rsp_overflow),
      .rsp_frame_length(rsp_frame_length)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTS) begin
         $display("ERROR @%0d: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   // ---------------- frame encoding predictor ----------------

   function automatic void clear_frame();
      code_pos  = 0;
      write_pos = 1;
      run_len   = 0;
      ovf_seen  = 1'b0;
   endfunction

   function automatic void put_write(input int unsigned addr, input int unsigned value,
                                     input bit term, input int unsigned length);
      frame_write_type w;
      w.addr   = addr[ADDR_W-1:0];
      w.value  = value[DATA_W-1:0];
      w.term   = term;
      w.ovf    = 1'b0;
      w.length = length[LEN_W-1:0];
      step_writes.push_back(w);
   endfunction

   // drop writes past the end of memory and flag them
   function automatic void store_write(input int unsigned addr, input int unsigned value);
      if (addr < FRAME_DEPTH) begin
         put_write(addr, value, 1'b0, 0);
      end else begin
         ovf_seen = 1'b1;
      end
   endfunction

   function automatic void bump_write();
      if (write_pos < FRAME_DEPTH) begin
         write_pos++;
      end
   endfunction

   function automatic void encode_byte(input logic [DATA_W-1:0] d, input logic last);
      bit          closed;
      int unsigned term_addr;
      closed = 1'b0;
      step_writes.delete();
      if (d != 0) begin
         store_write(write_pos, 32'(d));
         bump_write();
         run_len++;
         // close a full run with its code byte
         if (run_len >= MAX_RUN) begin
            store_write(code_pos, run_len + 1);
            if (last) begin
               closed = 1'b1;
            end else begin
               code_pos = write_pos;
               bump_write();
               run_len = 0;
            end
         end
      end else begin
         // patch the open code byte and reserve a new one
         store_write(code_pos, run_len + 1);
         code_pos = write_pos;
         bump_write();
         run_len = 0;
      end
      if (last) begin
         term_addr = write_pos;
         if (!closed) begin
            store_write(code_pos, run_len + 1);
         end
         if (term_addr >= FRAME_DEPTH) begin
            term_addr = FRAME_DEPTH - 1;
            ovf_seen  = 1'b1;
         end
         put_write(term_addr, 0, 1'b1, term_addr + 1);
      end
      // overflow is sticky up to the end of this byte
      foreach (step_writes[i]) begin
         step_writes[i].ovf = ovf_seen;
         frame_writes.push_back(step_writes[i]);
      end
      if (last) begin
         clear_frame();
      end
   endfunction

   task automatic check_write();
      frame_write_type w;
      if (frame_writes.size() == 0) begin
         report_error($sformatf("unexpected write addr=%0d value=%0d end=%0b",
                                rsp_frame_addr, rsp_frame_value, rsp_frame_end));
      end else begin
         w = frame_writes.pop_front();
         if (rsp_frame_addr !== w.addr)
            report_error($sformatf("frame_addr got %0d want %0d", rsp_frame_addr, w.addr));
         if (rsp_frame_value !== w.value)
            report_error($sformatf("frame_value got %0d want %0d at addr %0d",
                                   rsp_frame_value, w.value, w.addr));
         if (rsp_frame_end !== w.term)
            report_error($sformatf("frame_end got %0b want %0b at addr %0d",
                                   rsp_frame_end, w.term, w.addr));
         if (rsp_overflow !== w.ovf)
            report_error($sformatf("overflow got %0b want %0b at addr %0d",
                                   rsp_overflow, w.ovf, w.addr));
         if (rsp_frame_length !== w.length)
            report_error($sformatf("frame_length got %0d want %0d at addr %0d",
                                   rsp_frame_length, w.length, w.addr));
      end
   endtask

   // ---------------- stimulus ----------------

   task automatic push_byte(input logic [DATA_W-1:0] d, input logic last, input bit hold);
      payload_item_type p;
      p.data = d;
      p.last = last;
      p.hold = hold;
      pending_bytes.push_back(p);
   endtask

   task automatic add_frame(input int len, input int pct, input bit hold);
      logic [DATA_W-1:0] d;
      for (int i = 0; i < len; i++) begin
         d = ($urandom_range(0, 99) < pct) ? 8'd0 : DATA_W'($urandom_range(1, 255));
         push_byte(d, i == len - 1, hold && i == 0);
      end
   endtask

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("FAIL cobs_frame_encoder_unit");
         $finish;
      end
   end

   // sample both handshakes, predict accepted bytes, check accepted writes
   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (req_fire) begin
         encode_byte(req_data_byte, req_last_byte);
      end
      if (rsp_fire) begin
         writes_seen++;
         check_write();
      end
   end

   // drive payload bytes from the pending queue
   always @(negedge clock) begin
      bit nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nxt = offering;
         if (req_fire) begin
            pending_bytes.pop_front();
            nxt     = 1'b0;
            req_gap = no_idle ? 0 : $urandom_range(0, 5);
         end else if (!nxt && req_gap > 0) begin
            req_gap--;
         end
         // a held byte waits until every expected write has come out
         if (!nxt && req_gap == 0 && pending_bytes.size() > 0 &&
             !(pending_bytes[0].hold && frame_writes.size() > 0)) begin
            nxt = 1'b1;
            req_data_byte <= pending_bytes[0].data;
            req_last_byte <= pending_bytes[0].last;
         end
         offering = nxt;
         req_valid <= nxt;
      end
   end

   // stall the write port, once for a long stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_wait = no_idle ? 0 : $urandom_range(0, 5);
            if (writes_seen == HOLD_AT) begin
               rsp_wait = HOLD_OFF;
            end
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   initial begin
      // short frames: single byte, zero as final byte, zero runs, edge values
      push_byte(8'h01, 1'b1, 1'b0);
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h80, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'h55, 1'b0, 1'b0);
      push_byte(8'hAA, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h7F, 1'b0, 1'b0);
      push_byte(8'hFE, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h12, 1'b1, 1'b0);

      // random short frames with varied zero density
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: zero_pct = 0;
            1: zero_pct = 20;
            2: zero_pct = 50;
            default: zero_pct = 90;
         endcase
         frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                 : $urandom_range(1, 10);
         add_frame(frame_len, zero_pct, $urandom_range(0, 5) == 0);
         random_count += frame_len;
      end

      // short frames to close the run
      random_count = 0;
      while (random_count < 30) begin
         frame_len = $urandom_range(1, 8);
         add_frame(frame_len, 30, 1'b0);
         random_count += frame_len;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || offering) @(posedge clock);
      while (frame_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_writes.size() != 0) begin
         report_error($sformatf("%0d writes never came", frame_writes.size()));
      end
      if (error_count == 0) begin
         $display("PASS cobs_frame_encoder_unit");
      end else begin
         $display("FAIL cobs_frame_encoder_unit");
      end
      $finish;
   end

endmodule
